### rtl/u2u8_pkg.sv
// Package for the UCS-2 to UTF-8 encoder.
// Holds the queue entry type, the register indexes and the encoding constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u2u8_pkg;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned UNIT_W      = 16;
	localparam int unsigned TOTAL_W     = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_ONLY = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTE_LIMIT = 1'd1;

	localparam logic [UNIT_W-1:0] MAX_ONE_BYTE = 16'h007f;
	localparam logic [UNIT_W-1:0] MAX_TWO_BYTE = 16'h07ff;
	localparam logic [7:0]        LEAD_TWO     = 8'hc0;
	localparam logic [7:0]        LEAD_THREE   = 8'he0;
	localparam logic [7:0]        CONT_MARK    = 8'h80;
	localparam logic [5:0]        CONT_MASK    = 6'h3f;

	typedef struct packed {
		logic       is_end;
		logic [1:0] len;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} u2u8_entry_t;

endpackage

`default_nettype wire

### rtl/u2u8_in_if.sv
// Input channel of the UCS-2 to UTF-8 encoder: one code unit per transaction.
// Depends on u2u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface u2u8_in_if;
	logic                          valid;
	logic                          ready;
	logic [u2u8_pkg::UNIT_W-1:0]   code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink   (input valid, input code_unit, output ready);
endinterface

`default_nettype wire

### rtl/u2u8_out_if.sv
// Result channel of the UCS-2 to UTF-8 encoder: one byte result per transaction.
// Depends on u2u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface u2u8_out_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    out_byte;
	logic                          byte_valid;
	logic                          last;
	logic                          finished;
	logic [u2u8_pkg::TOTAL_W-1:0]  total_bytes;

	modport source (output valid, output out_byte, output byte_valid, output last,
		output finished, output total_bytes, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input last,
		input finished, input total_bytes, output ready);
endinterface

`default_nettype wire

### rtl/u2u8_front.sv
// Front end: accepts code units, splits them into UTF-8 byte sequences and
// holds them in a two-entry queue. Depends on u2u8_pkg and u2u8_in_if.
`timescale 1ns / 1ps
`default_nettype none

module u2u8_front (
	input  wire                       clk,
	input  wire                       arst_n,
	u2u8_in_if.sink                   in_ch,
	output u2u8_pkg::u2u8_entry_t     head,
	output logic                      head_valid,
	input  wire                       pop
);

	u2u8_pkg::u2u8_entry_t entry_c;
	u2u8_pkg::u2u8_entry_t queue_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;
	logic                  push;
	logic                  do_pop;
	logic [15:0]           cu;

	assign cu = in_ch.code_unit;

	always_comb begin
		entry_c.is_end = (cu == '0);
		entry_c.b1     = u2u8_pkg::CONT_MARK | {2'b00, cu[11:6] & u2u8_pkg::CONT_MASK};
		entry_c.b2     = u2u8_pkg::CONT_MARK | {2'b00, cu[5:0] & u2u8_pkg::CONT_MASK};
		if (cu <= u2u8_pkg::MAX_ONE_BYTE) begin
			entry_c.len = 2'd1;
			entry_c.b0  = cu[7:0];
		end else if (cu <= u2u8_pkg::MAX_TWO_BYTE) begin
			entry_c.len = 2'd2;
			entry_c.b0  = u2u8_pkg::LEAD_TWO | {3'b000, cu[10:6]};
			entry_c.b1  = u2u8_pkg::CONT_MARK | {2'b00, cu[5:0] & u2u8_pkg::CONT_MASK};
		end else begin
			entry_c.len = 2'd3;
			entry_c.b0  = u2u8_pkg::LEAD_THREE | {4'b0000, cu[15:12]};
		end
	end

	assign in_ch.ready = (fill_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (fill_q != 2'd0);
	assign do_pop      = pop && head_valid;
	assign head        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/u2u8_back.sv
// Back end: walks queued byte sequences one byte per cycle while the result
// channel is not stalled, keeps the running count and the limit state, and
// drives the registered result channel. Depends on u2u8_pkg and u2u8_out_if.
`timescale 1ns / 1ps
`default_nettype none

module u2u8_back #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  u2u8_pkg::u2u8_entry_t             head,
	input  wire                               head_valid,
	output logic                              pop,
	input  wire                               count_only,
	input  wire [u2u8_pkg::CFG_DATA_W-1:0]    byte_limit,
	u2u8_out_if.source                        out_ch
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > u2u8_pkg::CFG_DATA_W) ?
		COUNT_WIDTH : u2u8_pkg::CFG_DATA_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   limit_hit_q;
	logic [1:0]             idx_q;

	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   byte_valid_q;
	logic                   last_q;
	logic                   finished_q;
	logic [u2u8_pkg::TOTAL_W-1:0] total_q;

	logic                   load;
	logic [COUNT_WIDTH:0]   sum_len;
	logic [COUNT_WIDTH:0]   sum_one;
	logic [COUNT_WIDTH-1:0] cnt_len;
	logic [COUNT_WIDTH-1:0] cnt_one;
	logic                   stopped;
	logic                   hit;
	logic                   seq_last;
	logic [7:0]             cur_byte;

	logic [COUNT_WIDTH-1:0] count_d;
	logic                   limit_hit_d;
	logic [1:0]             idx_d;
	logic [7:0]             ob_d;
	logic                   bv_d;
	logic                   last_d;
	logic                   fin_d;

	assign load    = head_valid && (!out_valid_q || out_ch.ready);
	assign sum_len = {1'b0, count_q} + (COUNT_WIDTH + 1)'(head.len);
	assign sum_one = {1'b0, count_q} + (COUNT_WIDTH + 1)'(1);
	assign cnt_len = sum_len[COUNT_WIDTH] ? '1 : sum_len[COUNT_WIDTH-1:0];
	assign cnt_one = sum_one[COUNT_WIDTH] ? '1 : sum_one[COUNT_WIDTH-1:0];
	assign stopped = (byte_limit == '0) || limit_hit_q;
	assign hit     = CMP_W'(cnt_one) >= CMP_W'(byte_limit);
	assign seq_last = (idx_q == head.len - 2'd1);

	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = head.b0;
			2'd1:    cur_byte = head.b1;
			default: cur_byte = head.b2;
		endcase
	end

	always_comb begin
		count_d     = count_q;
		limit_hit_d = limit_hit_q;
		idx_d       = idx_q;
		ob_d        = 8'h00;
		bv_d        = 1'b0;
		last_d      = 1'b1;
		fin_d       = 1'b1;
		pop         = 1'b0;
		if (load) begin
			if (head.is_end) begin
				bv_d        = !count_only && !stopped;
				count_d     = '0;
				limit_hit_d = 1'b0;
				pop         = 1'b1;
			end else if (count_only) begin
				count_d = cnt_len;
				fin_d   = 1'b0;
				pop     = 1'b1;
			end else if (stopped) begin
				pop = 1'b1;
			end else begin
				count_d = cnt_one;
				ob_d    = cur_byte;
				bv_d    = 1'b1;
				if (hit) begin
					limit_hit_d = 1'b1;
					idx_d       = 2'd0;
					pop         = 1'b1;
				end else begin
					fin_d  = 1'b0;
					last_d = seq_last;
					if (seq_last) begin
						idx_d = 2'd0;
						pop   = 1'b1;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_hit_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			limit_hit_q <= limit_hit_d;
			idx_q       <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= ob_d;
			byte_valid_q <= bv_d;
			last_q       <= last_d;
			finished_q   <= fin_d;
			total_q      <= u2u8_pkg::TOTAL_W'(head.is_end ? count_q : count_d);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.byte_valid  = byte_valid_q;
	assign out_ch.last        = last_q;
	assign out_ch.finished    = finished_q;
	assign out_ch.total_bytes = total_q;

endmodule

`default_nettype wire

### rtl/ucs2_to_utf8_encoder_unit.sv
// UCS-2 to UTF-8 encoder, top level: configuration registers, front end with
// its queue, and the byte-serial back end. Depends on u2u8_pkg and the channel interfaces.
// Path: a code unit goes through the front-end queue, then the back-end output register.
// Rate: the back end emits one byte per cycle into its output register while the result
// channel is not stalled; in count-only mode it takes one whole code unit per result.
// Reset: clears the queue, the count, the limit state and both config registers.
`timescale 1ns / 1ps
`default_nettype none

module ucs2_to_utf8_encoder_unit #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [u2u8_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire [u2u8_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	u2u8_in_if.sink                            in_ch,
	u2u8_out_if.source                         out_ch
);

	logic                              count_only_q;
	logic [u2u8_pkg::CFG_DATA_W-1:0]   byte_limit_q;
	u2u8_pkg::u2u8_entry_t             head;
	logic                              head_valid;
	logic                              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q <= 1'b0;
			byte_limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				u2u8_pkg::REG_COUNT_ONLY: count_only_q <= cfg_wdata[0];
				u2u8_pkg::REG_BYTE_LIMIT: byte_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	u2u8_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.count_only (count_only_q),
		.byte_limit (byte_limit_q),
		.out_ch     (out_ch)
	);

endmodule

`default_nettype wire
